@@ hdl/limited_travel_motor_positioner_top_assert.svh @@
// assertion macros used by the checker
`ifndef LIMITED_TRAVEL_MOTOR_POSITIONER_TOP_ASSERT_SVH
`define LIMITED_TRAVEL_MOTOR_POSITIONER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LTMP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ltmp check failed");

// antecedent implies consequent in the next cycle
`define LTMP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ltmp check failed");

`endif

@@ hdl/ltmp_pkg.sv @@
`default_nettype none

package ltmp_pkg;

   localparam int SV_W     = 32;
   localparam int DUTY_W   = 16;
   localparam int SUPPLY_W = 16;
   localparam int POS_W    = 10;
   localparam int SCALE_W  = 7;
   localparam int PROD_W   = DUTY_W + SCALE_W;
   localparam int CNT_W    = 5;
   localparam int CSR_W    = 2;

   localparam logic [POS_W:0]     NEAR_BAND    = (POS_W+1)'(3);
   localparam logic [POS_W-1:0]   TOP_RESET    = POS_W'(405);
   localparam logic [SCALE_W:0]   DUTY_DIVISOR = (SCALE_W+1)'(100);
   localparam logic [SCALE_W-1:0] ROUND_LIMIT  = SCALE_W'(50);

   localparam logic [CSR_W-1:0] CSR_SET_VOLTAGE  = CSR_W'(0);
   localparam logic [CSR_W-1:0] CSR_FULL_DUTY    = CSR_W'(1);
   localparam logic [CSR_W-1:0] CSR_TOP_POSITION = CSR_W'(2);

   typedef enum logic [1:0] {
      KIND_TARGET = 2'd0,
      KIND_DOWN   = 2'd1,
      KIND_UP     = 2'd2,
      KIND_IDLE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      DUTY_IDLE,
      DUTY_DIV,
      DUTY_MUL,
      DUTY_RED,
      DUTY_FIN
   } duty_state_type;

   typedef struct packed {
      logic start;
      logic take;
   } duty_cmd_type;

   typedef struct packed {
      logic              ready;
      logic              fin;
      logic [DUTY_W-1:0] duty;
   } duty_stat_type;

endpackage

`default_nettype wire

@@ hdl/ltmp_duty.sv @@
`default_nettype none

module ltmp_duty (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ltmp_pkg::duty_cmd_type             cmd,
   input  wire logic [ltmp_pkg::SV_W-1:0]          set_voltage,
   input  wire logic [ltmp_pkg::SUPPLY_W-1:0]      supply_voltage,
   input  wire logic [ltmp_pkg::DUTY_W-1:0]        full_duty,
   output      ltmp_pkg::duty_stat_type            stat
);

   localparam int SV_W     = ltmp_pkg::SV_W;
   localparam int SUPPLY_W = ltmp_pkg::SUPPLY_W;
   localparam int DUTY_W   = ltmp_pkg::DUTY_W;
   localparam int SCALE_W  = ltmp_pkg::SCALE_W;
   localparam int PROD_W   = ltmp_pkg::PROD_W;
   localparam int CNT_W    = ltmp_pkg::CNT_W;

   ltmp_pkg::duty_state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SV_W-1:0]     sv_ff, sv_in;
   logic [SUPPLY_W-1:0] sup_ff, sup_in;
   logic [SUPPLY_W-1:0] rem_ff, rem_in;
   logic [SV_W-1:0]     quo_ff, quo_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SCALE_W-1:0]  rrem_ff, rrem_in;
   logic [DUTY_W-1:0]   duty_ff, duty_in;

   logic [SUPPLY_W:0]   div_trial;
   logic [SUPPLY_W:0]   div_diff;
   logic                div_ge;
   logic [SV_W-1:0]     div_quo;
   logic                compensated;
   logic [PROD_W-1:0]   mul_sum;
   logic [SCALE_W:0]    red_trial;
   logic [SCALE_W:0]    red_diff;
   logic                red_ge;
   logic [SCALE_W-1:0]  red_rem;
   logic [PROD_W-1:0]   red_quo;
   logic [DUTY_W:0]     round_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ltmp_pkg::DUTY_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      sv_ff   <= sv_in;
      sup_ff  <= sup_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      prod_ff <= prod_in;
      rrem_ff <= rrem_in;
      duty_ff <= duty_in;
   end

   // restoring divide of set_voltage by supply, one dividend bit per cycle
   assign div_trial   = {rem_ff, sv_ff[SV_W-1]};
   assign div_ge      = div_trial >= {1'b0, sup_ff};
   assign div_diff    = div_trial - {1'b0, sup_ff};
   assign div_quo     = {quo_ff[SV_W-2:0], div_ge};
   assign compensated = (div_quo[SV_W-1:SCALE_W] == '0)
                        && ({1'b0, div_quo[SCALE_W-1:0]} < ltmp_pkg::DUTY_DIVISOR);

   // shift-add multiply, scale msb first
   assign mul_sum = {prod_ff[PROD_W-2:0], 1'b0}
                    + (quo_ff[SV_W-1] ? PROD_W'(full_duty) : PROD_W'(0));

   // restoring divide by 100, product msb first
   assign red_trial = {rrem_ff, prod_ff[PROD_W-1]};
   assign red_ge    = red_trial >= ltmp_pkg::DUTY_DIVISOR;
   assign red_diff  = red_trial - ltmp_pkg::DUTY_DIVISOR;
   assign red_rem   = red_ge ? red_diff[SCALE_W-1:0] : red_trial[SCALE_W-1:0];
   assign red_quo   = {prod_ff[PROD_W-2:0], red_ge};
   assign round_sum = {1'b0, red_quo[DUTY_W-1:0]}
                      + (DUTY_W+1)'(red_rem > ltmp_pkg::ROUND_LIMIT);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sv_in    = sv_ff;
      sup_in   = sup_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      prod_in  = prod_ff;
      rrem_in  = rrem_ff;
      duty_in  = duty_ff;
      unique case (state_ff)
         ltmp_pkg::DUTY_IDLE: begin
            if (cmd.start) begin
               sv_in    = set_voltage;
               sup_in   = supply_voltage;
               rem_in   = '0;
               cnt_in   = CNT_W'(SV_W - 1);
               state_in = ltmp_pkg::DUTY_DIV;
            end
         end
         ltmp_pkg::DUTY_DIV: begin
            sv_in  = {sv_ff[SV_W-2:0], 1'b0};
            rem_in = div_ge ? div_diff[SUPPLY_W-1:0] : div_trial[SUPPLY_W-1:0];
            quo_in = div_quo;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               if (compensated) begin
                  prod_in  = '0;
                  quo_in   = div_quo << (SV_W - SCALE_W);
                  cnt_in   = CNT_W'(SCALE_W - 1);
                  state_in = ltmp_pkg::DUTY_MUL;
               end else begin
                  duty_in  = full_duty;
                  state_in = ltmp_pkg::DUTY_FIN;
               end
            end
         end
         ltmp_pkg::DUTY_MUL: begin
            prod_in = mul_sum;
            quo_in  = {quo_ff[SV_W-2:0], 1'b0};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               rrem_in  = '0;
               cnt_in   = CNT_W'(PROD_W - 1);
               state_in = ltmp_pkg::DUTY_RED;
            end
         end
         ltmp_pkg::DUTY_RED: begin
            prod_in = red_quo;
            rrem_in = red_rem;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               if ((red_quo[PROD_W-1:DUTY_W] != '0) || round_sum[DUTY_W]) begin
                  duty_in = '1;
               end else begin
                  duty_in = round_sum[DUTY_W-1:0];
               end
               state_in = ltmp_pkg::DUTY_FIN;
            end
         end
         ltmp_pkg::DUTY_FIN: begin
            if (cmd.take) begin
               state_in = ltmp_pkg::DUTY_IDLE;
            end
         end
         default: begin
            state_in = ltmp_pkg::DUTY_IDLE;
         end
      endcase
   end

   assign stat.ready = state_ff == ltmp_pkg::DUTY_IDLE;
   assign stat.fin   = state_ff == ltmp_pkg::DUTY_FIN;
   assign stat.duty  = duty_ff;

endmodule

`default_nettype wire

@@ hdl/limited_travel_motor_positioner_top.sv @@
// Motor positioner: one command transaction in, one result transaction out.
// The run/brake decision, end-stop reload and direction line are settled when
// the command is taken; the supply-compensated duty then comes from a
// bit-serial unit: a restoring divide of set_voltage by the supply, a shift-add
// multiply by full_duty and a divide by 100 with rounding, the last two only
// when compensation applies. The next command is not taken until the unit has
// passed its result on; a finished result waits in the output register, so
// the next command is taken while the previous result is still stalled.

`default_nettype none

module limited_travel_motor_positioner_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [9:0]  req_target_position,
   input  wire logic [9:0]  req_current_position,
   input  wire logic        req_up_limit,
   input  wire logic        req_down_limit,
   input  wire logic        req_driver_fault,
   input  wire logic [15:0] req_supply_voltage,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_done_res,
   output      logic        rsp_motor_on,
   output      logic        rsp_direction_down,
   output      logic [15:0] rsp_duty,
   output      logic        rsp_position_load,
   output      logic [9:0]  rsp_position_value,
   output      logic        rsp_driver_reset_pulse
);

   localparam int POS_W  = ltmp_pkg::POS_W;
   localparam int DUTY_W = ltmp_pkg::DUTY_W;
   localparam int SV_W   = ltmp_pkg::SV_W;

   logic [SV_W-1:0]   set_voltage_ff, set_voltage_in;
   logic [DUTY_W-1:0] full_duty_ff, full_duty_in;
   logic [POS_W-1:0]  top_position_ff, top_position_in;
   logic              direction_ff, direction_in;

   logic              dec_done_ff, dec_done_in;
   logic              dec_drive_ff, dec_drive_in;
   logic              dec_dir_ff, dec_dir_in;
   logic              dec_load_ff, dec_load_in;
   logic [POS_W-1:0]  dec_value_ff, dec_value_in;
   logic              dec_pulse_ff, dec_pulse_in;
   logic              dec_want_ff, dec_want_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_done_ff, rsp_done_in;
   logic              rsp_motor_ff, rsp_motor_in;
   logic              rsp_dir_ff, rsp_dir_in;
   logic [DUTY_W-1:0] rsp_duty_ff, rsp_duty_in;
   logic              rsp_load_ff, rsp_load_in;
   logic [POS_W-1:0]  rsp_value_ff, rsp_value_in;
   logic              rsp_pulse_ff, rsp_pulse_in;

   ltmp_pkg::duty_cmd_type  duty_cmd;
   ltmp_pkg::duty_stat_type duty_stat;

   logic             req_accept;
   logic             take;
   logic             move_up;
   logic             move_down;
   logic             near;
   logic             far_up;
   logic             far_down;

   ltmp_duty u_duty (
      .clock          (clock),
      .reset          (reset),
      .cmd            (duty_cmd),
      .set_voltage    (set_voltage_ff),
      .supply_voltage (req_supply_voltage),
      .full_duty      (full_duty_ff),
      .stat           (duty_stat)
   );

   assign req_accept     = req_valid && duty_stat.ready;
   assign req_stall      = !duty_stat.ready;
   assign take           = duty_stat.fin && (!rsp_valid_ff || !rsp_stall);
   assign duty_cmd.start = req_accept;
   assign duty_cmd.take  = take;

   // csr writes
   always_comb begin
      set_voltage_in  = set_voltage_ff;
      full_duty_in    = full_duty_ff;
      top_position_in = top_position_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            ltmp_pkg::CSR_SET_VOLTAGE:  set_voltage_in  = csr_data;
            ltmp_pkg::CSR_FULL_DUTY:    full_duty_in    = csr_data[DUTY_W-1:0];
            ltmp_pkg::CSR_TOP_POSITION: top_position_in = csr_data[POS_W-1:0];
            default: ;
         endcase
      end
   end

   // command decision
   assign far_up   = {1'b0, req_target_position}
                     > ({1'b0, req_current_position} + ltmp_pkg::NEAR_BAND);
   assign far_down = ({1'b0, req_target_position} + ltmp_pkg::NEAR_BAND)
                     < {1'b0, req_current_position};

   always_comb begin
      move_up   = 1'b0;
      move_down = 1'b0;
      near      = 1'b0;
      unique case (ltmp_pkg::kind_type'(req_kind))
         ltmp_pkg::KIND_TARGET: begin
            move_up   = far_up;
            move_down = !far_up && far_down;
            near      = !far_up && !far_down;
         end
         ltmp_pkg::KIND_DOWN: move_down = 1'b1;
         ltmp_pkg::KIND_UP:   move_up   = 1'b1;
         ltmp_pkg::KIND_IDLE: near      = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      direction_in = direction_ff;
      dec_done_in  = dec_done_ff;
      dec_drive_in = dec_drive_ff;
      dec_dir_in   = dec_dir_ff;
      dec_load_in  = dec_load_ff;
      dec_value_in = dec_value_ff;
      dec_pulse_in = dec_pulse_ff;
      dec_want_in  = dec_want_ff;
      if (req_accept) begin
         dec_done_in  = near;
         dec_drive_in = 1'b0;
         dec_load_in  = 1'b0;
         dec_value_in = '0;
         if (move_up) begin
            if (req_up_limit) begin
               dec_load_in  = 1'b1;
               dec_value_in = top_position_ff;
               dec_done_in  = 1'b1;
            end else begin
               direction_in = 1'b0;
               dec_drive_in = 1'b1;
            end
         end else if (move_down) begin
            if (req_down_limit) begin
               dec_load_in = 1'b1;
               dec_done_in = 1'b1;
            end else begin
               direction_in = 1'b1;
               dec_drive_in = 1'b1;
            end
         end
         dec_want_in  = dec_drive_in && (full_duty_ff != '0);
         dec_pulse_in = dec_want_in && req_driver_fault;
         dec_dir_in   = direction_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = take || (rsp_valid_ff && rsp_stall);
      rsp_done_in  = rsp_done_ff;
      rsp_motor_in = rsp_motor_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_load_in  = rsp_load_ff;
      rsp_value_in = rsp_value_ff;
      rsp_pulse_in = rsp_pulse_ff;
      if (take) begin
         rsp_done_in  = dec_done_ff;
         rsp_motor_in = dec_drive_ff;
         rsp_dir_in   = dec_dir_ff;
         rsp_duty_in  = dec_want_ff ? duty_stat.duty : '0;
         rsp_load_in  = dec_load_ff;
         rsp_value_in = dec_value_ff;
         rsp_pulse_in = dec_pulse_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_voltage_ff  <= '0;
         full_duty_ff    <= '0;
         top_position_ff <= ltmp_pkg::TOP_RESET;
         direction_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         set_voltage_ff  <= set_voltage_in;
         full_duty_ff    <= full_duty_in;
         top_position_ff <= top_position_in;
         direction_ff    <= direction_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_done_ff  <= dec_done_in;
      dec_drive_ff <= dec_drive_in;
      dec_dir_ff   <= dec_dir_in;
      dec_load_ff  <= dec_load_in;
      dec_value_ff <= dec_value_in;
      dec_pulse_ff <= dec_pulse_in;
      dec_want_ff  <= dec_want_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_motor_ff <= rsp_motor_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_load_ff  <= rsp_load_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pulse_ff <= rsp_pulse_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_done_res           = rsp_done_ff;
   assign rsp_motor_on           = rsp_motor_ff;
   assign rsp_direction_down     = rsp_dir_ff;
   assign rsp_duty               = rsp_duty_ff;
   assign rsp_position_load      = rsp_load_ff;
   assign rsp_position_value     = rsp_value_ff;
   assign rsp_driver_reset_pulse = rsp_pulse_ff;

endmodule

`default_nettype wire

@@ hdl/ltmp_checker.sv @@
`default_nettype none

`include "limited_travel_motor_positioner_top_assert.svh"

module ltmp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_done_res,
   input wire logic        rsp_motor_on,
   input wire logic [15:0] rsp_duty,
   input wire logic        rsp_position_load,
   input wire logic [9:0]  rsp_position_value,
   input wire logic        rsp_driver_reset_pulse
);

   // a taken transaction keeps the input stalled while the duty is worked out
   `LTMP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // a stalled result holds
   `LTMP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_duty) && $stable(rsp_motor_on))

   // braking gives no duty and no reset pulse
   `LTMP_ASSERT_SAME(a_brake_quiet, clock, reset, rsp_valid && !rsp_motor_on,
      rsp_duty == 16'd0 && !rsp_driver_reset_pulse)

   // a reload only at an end stop, which brakes and finishes
   `LTMP_ASSERT_SAME(a_reload_done, clock, reset, rsp_valid && rsp_position_load,
      rsp_done_res && !rsp_motor_on)

   `LTMP_ASSERT_SAME(a_no_reload_zero, clock, reset, rsp_valid && !rsp_position_load,
      rsp_position_value == 10'd0)

endmodule

bind limited_travel_motor_positioner_top ltmp_checker u_ltmp_checker (.*);

`default_nettype wire

@@ bench/limited_travel_motor_positioner_checker.sv @@
`timescale 1ns / 100ps

module limited_travel_motor_positioner_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [9:0]  req_target_position,
   input  logic [9:0]  req_current_position,
   input  logic        req_up_limit,
   input  logic        req_down_limit,
   input  logic        req_driver_fault,
   input  logic [15:0] req_supply_voltage,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_done_res,
   input  logic        rsp_motor_on,
   input  logic        rsp_direction_down,
   input  logic [15:0] rsp_duty,
   input  logic        rsp_position_load,
   input  logic [9:0]  rsp_position_value,
   input  logic        rsp_driver_reset_pulse,
   output int          failures,
   output int          outstanding
);

   typedef struct packed {
      logic        done_res;
      logic        motor_on;
      logic        direction_down;
      logic [15:0] duty;
      logic        position_load;
      logic [9:0]  position_value;
      logic        driver_reset_pulse;
   } motor_outcome_type;

   logic [31:0] cfg_volt;
   logic [15:0] cfg_full;
   logic [9:0]  cfg_top;
   logic        dir_line;

   motor_outcome_type waiting_outcomes[$];
   motor_outcome_type want;

   initial begin
      failures = 0;
      outstanding = 0;
   end

   function automatic logic [15:0] compensated_duty(input logic [15:0] full,
                                                    input logic [15:0] supply,
                                                    input logic [31:0] volt);
      logic [31:0] scale;
      logic [47:0] prod;
      logic [47:0] quot;
      if ({16'b0, supply} <= volt / 32'd100) begin
         return full;
      end
      scale = volt / {16'b0, supply};
      prod = {32'b0, full} * {16'b0, scale};
      quot = prod / 48'd100;
      if (prod % 48'd100 > 48'd50) begin
         quot = quot + 48'd1;
      end
      if (quot > 48'd65535) begin
         quot = 48'd65535;
      end
      return quot[15:0];
   endfunction

   function automatic motor_outcome_type predict_outcome(input logic [1:0]  kind,
                                                         input logic [9:0]  target,
                                                         input logic [9:0]  current,
                                                         input logic        up_hit,
                                                         input logic        down_hit,
                                                         input logic        fault,
                                                         input logic [15:0] supply,
                                                         input logic        dir_in);
      motor_outcome_type res;
      int tgt;
      int cur;
      int move;
      res = '0;
      res.direction_down = dir_in;
      tgt = int'(target);
      cur = int'(current);
      move = 0;
      case (ltmp_pkg::kind_type'(kind))
         ltmp_pkg::KIND_TARGET: begin
            if (tgt > cur + int'(ltmp_pkg::NEAR_BAND)) begin
               move = 1;
            end else if (tgt + int'(ltmp_pkg::NEAR_BAND) < cur) begin
               move = -1;
            end else begin
               res.done_res = 1'b1;
            end
         end
         ltmp_pkg::KIND_DOWN: move = -1;
         ltmp_pkg::KIND_UP:   move = 1;
         ltmp_pkg::KIND_IDLE: res.done_res = 1'b1;
      endcase
      if (move == 1) begin
         if (up_hit) begin
            res.position_load = 1'b1;
            res.position_value = cfg_top;
            res.done_res = 1'b1;
         end else begin
            res.direction_down = 1'b0;
            res.motor_on = 1'b1;
         end
      end else if (move == -1) begin
         if (down_hit) begin
            res.position_load = 1'b1;
            res.position_value = '0;
            res.done_res = 1'b1;
         end else begin
            res.direction_down = 1'b1;
            res.motor_on = 1'b1;
         end
      end
      if (res.motor_on && cfg_full != 16'd0) begin
         res.driver_reset_pulse = fault;
         res.duty = compensated_duty(cfg_full, supply, cfg_volt);
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_volt = '0;
         cfg_full = '0;
         cfg_top = ltmp_pkg::TOP_RESET;
         dir_line = 1'b0;
         waiting_outcomes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (waiting_outcomes.size() == 0) begin
               $error("result transaction with no command waiting");
               failures++;
            end else begin
               want = waiting_outcomes.pop_front();
               check_field("done_res", 32'(want.done_res), 32'(rsp_done_res));
               check_field("motor_on", 32'(want.motor_on), 32'(rsp_motor_on));
               check_field("direction_down", 32'(want.direction_down),
                           32'(rsp_direction_down));
               check_field("duty", 32'(want.duty), 32'(rsp_duty));
               check_field("position_load", 32'(want.position_load),
                           32'(rsp_position_load));
               check_field("position_value", 32'(want.position_value),
                           32'(rsp_position_value));
               check_field("driver_reset_pulse", 32'(want.driver_reset_pulse),
                           32'(rsp_driver_reset_pulse));
            end
         end
         if (req_valid && !req_stall) begin
            want = predict_outcome(req_kind, req_target_position, req_current_position,
                                   req_up_limit, req_down_limit, req_driver_fault,
                                   req_supply_voltage, dir_line);
            dir_line = want.direction_down;
            waiting_outcomes.push_back(want);
         end
         if (csr_write_enable) begin
            case (csr_index)
               ltmp_pkg::CSR_SET_VOLTAGE:  cfg_volt = csr_data;
               ltmp_pkg::CSR_FULL_DUTY:    cfg_full = csr_data[15:0];
               ltmp_pkg::CSR_TOP_POSITION: cfg_top = csr_data[9:0];
               default: ;
            endcase
         end
      end
      outstanding <= waiting_outcomes.size();
   end

endmodule

@@ bench/limited_travel_motor_positioner_top_test.sv @@
`timescale 1ns / 100ps

module limited_travel_motor_positioner_top_test;

   localparam int QUIET_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = '0;
   logic [9:0]  req_target_position = '0;
   logic [9:0]  req_current_position = '0;
   logic        req_up_limit = 1'b0;
   logic        req_down_limit = 1'b0;
   logic        req_driver_fault = 1'b0;
   logic [15:0] req_supply_voltage = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_done_res;
   logic        rsp_motor_on;
   logic        rsp_direction_down;
   logic [15:0] rsp_duty;
   logic        rsp_position_load;
   logic [9:0]  rsp_position_value;
   logic        rsp_driver_reset_pulse;
   int          failures;
   int          outstanding;

   logic [31:0] cfg_volt = '0;
   int          hold_cycles = 0;
   int          quiet_cycles = 0;

   limited_travel_motor_positioner_top u_top (.*);

   limited_travel_motor_positioner_checker u_checker (.*);

   always #5 clock = ~clock;

   // result side back-pressure
   always @(posedge clock) begin
      int pick;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_cycles == 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            rsp_stall <= 1'b0;
            hold_cycles <= $urandom_range(1, 20);
         end else if (pick < 90) begin
            rsp_stall <= 1'b1;
            hold_cycles <= $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            hold_cycles <= $urandom_range(20, 100);
         end
      end else begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic drive_command(input ltmp_pkg::kind_type k, input logic [9:0] tgt,
                                input logic [9:0] cur, input logic up_hit,
                                input logic down_hit, input logic fault,
                                input logic [15:0] supply);
      int pick;
      int gap;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         gap = 0;
      end else if (pick < 90) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(10, 60);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_target_position <= tgt;
      req_current_position <= cur;
      req_up_limit <= up_hit;
      req_down_limit <= down_hit;
      req_driver_fault <= fault;
      req_supply_voltage <= supply;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [31:0] volt, input logic [15:0] full,
                                input logic [9:0] top);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index <= ltmp_pkg::CSR_SET_VOLTAGE;
      csr_data <= volt;
      @(posedge clock);
      csr_index <= ltmp_pkg::CSR_FULL_DUTY;
      csr_data <= {16'b0, full};
      @(posedge clock);
      csr_index <= ltmp_pkg::CSR_TOP_POSITION;
      csr_data <= {22'b0, top};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_volt = volt;
   endtask

   task automatic random_commands(input int count);
      ltmp_pkg::kind_type k;
      logic [9:0]  cur;
      logic [9:0]  tgt;
      longint      t;
      int          pick;
      repeat (count) begin
         k = ltmp_pkg::kind_type'($urandom_range(0, 3));
         cur = 10'($urandom_range(0, 1023));
         if ($urandom_range(0, 1) == 1) begin
            t = longint'(cur) + longint'($urandom_range(0, 12)) - 6;
            if (t < 0) t = 0;
            if (t > 1023) t = 1023;
            tgt = t[9:0];
         end else begin
            tgt = 10'($urandom_range(0, 1023));
         end
         pick = $urandom_range(0, 9);
         case (pick)
            0: t = 0;
            1: t = longint'(cfg_volt / 32'd100) + longint'($urandom_range(0, 2)) - 1;
            2, 3: t = longint'(cfg_volt / $urandom_range(1, 99));
            default: t = longint'($urandom_range(0, 65535));
         endcase
         if (t < 0) t = 0;
         if (t > 65535) t = 65535;
         drive_command(k, tgt, cur, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                       $urandom_range(0, 2) == 0, t[15:0]);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      random_commands(20);

      apply_setting(32'd10000, 16'd25, 10'd1023);
      drive_command(ltmp_pkg::KIND_TARGET, 10'd503, 10'd500, 1'b0, 1'b0, 1'b0, 16'd0);
      drive_command(ltmp_pkg::KIND_TARGET, 10'd504, 10'd500, 1'b0, 1'b0, 1'b0, 16'd100);
      drive_command(ltmp_pkg::KIND_TARGET, 10'd497, 10'd500, 1'b0, 1'b0, 1'b0, 16'd101);
      drive_command(ltmp_pkg::KIND_TARGET, 10'd496, 10'd500, 1'b0, 1'b0, 1'b0, 16'd101);
      drive_command(ltmp_pkg::KIND_TARGET, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b0, 16'd3333);
      drive_command(ltmp_pkg::KIND_TARGET, 10'd0, 10'd1023, 1'b0, 1'b0, 1'b0, 16'd3334);
      drive_command(ltmp_pkg::KIND_TARGET, 10'd1023, 10'd1020, 1'b0, 1'b0, 1'b0, 16'd200);
      drive_command(ltmp_pkg::KIND_TARGET, 10'd1020, 10'd1023, 1'b0, 1'b0, 1'b0, 16'd200);
      drive_command(ltmp_pkg::KIND_UP, 10'd0, 10'd0, 1'b1, 1'b0, 1'b0, 16'd500);
      drive_command(ltmp_pkg::KIND_DOWN, 10'd1023, 10'd1023, 1'b0, 1'b1, 1'b0, 16'd500);
      drive_command(ltmp_pkg::KIND_TARGET, 10'd900, 10'd100, 1'b1, 1'b0, 1'b1, 16'd500);
      drive_command(ltmp_pkg::KIND_TARGET, 10'd100, 10'd900, 1'b0, 1'b1, 1'b1, 16'd500);
      drive_command(ltmp_pkg::KIND_UP, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1, 16'hFFFF);
      drive_command(ltmp_pkg::KIND_DOWN, 10'd0, 10'd0, 1'b0, 1'b0, 1'b1, 16'd5000);
      drive_command(ltmp_pkg::KIND_IDLE, 10'd0, 10'd0, 1'b1, 1'b1, 1'b1, 16'hFFFF);
      drive_command(ltmp_pkg::KIND_TARGET, 10'd500, 10'd500, 1'b0, 1'b0, 1'b1, 16'd300);
      drive_command(ltmp_pkg::KIND_UP, 10'h3FF, 10'h3FF, 1'b0, 1'b1, 1'b0, 16'hFFFF);
      drive_command(ltmp_pkg::KIND_DOWN, 10'd0, 10'd0, 1'b1, 1'b0, 1'b0, 16'd0);
      drive_command(ltmp_pkg::KIND_IDLE, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 16'd0);
      random_commands(150);

      apply_setting(32'd0, 16'hFFFF, 10'd0);
      random_commands(130);

      apply_setting(32'hFFFF_FFFF, 16'hFFFF, 10'd512);
      random_commands(130);

      apply_setting($urandom_range(0, 6553500), 16'($urandom_range(1, 65535)),
                    10'($urandom_range(0, 1023)));
      random_commands(150);

      apply_setting(32'd120000, 16'd0, 10'd405);
      random_commands(100);

      apply_setting($urandom, 16'($urandom_range(0, 65535)), 10'($urandom_range(0, 1023)));
      random_commands(130);

      apply_setting($urandom_range(0, 6553500), 16'($urandom_range(1, 65535)),
                    10'($urandom_range(0, 1023)));
      random_commands(150);

      wait_drained();
      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
